FILE: rtl/core/prime_sieve_engine_core_defines.svh
// assertion macros shared by the sieve engine modules
// no dependencies; expects clk and arst_n in the module that uses them
`ifndef PRIME_SIEVE_ENGINE_CORE_DEFINES_SVH
`define PRIME_SIEVE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define PSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/pse_pkg.sv
// types and constants of the prime sieve engine
// no dependencies
package pse_pkg;

	localparam int VAL_W = 16;
	localparam int CNT_W = VAL_W + 1;
	localparam int FAC_W = VAL_W / 2 + 1;

	localparam logic OP_BUILD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_RANGE    = 2'd1;
	localparam logic [1:0] STAT_NO_BUILD = 2'd2;

	localparam logic [VAL_W-1:0] LIMIT_RESET = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_FREAD,
		ST_FCHECK,
		ST_STRIKE,
		ST_DONE
	} pse_state_t;

	typedef struct packed {
		logic build_load;
		logic qry_load;
		logic init_wr;
		logic rd_factor;
		logic strike_load;
		logic strike_wr;
		logic next_factor;
		logic done;
	} pse_cmd_t;

	typedef struct packed {
		logic init_last;
		logic sq_over;
		logic factor_prime;
		logic strike_last;
	} pse_stat_t;

endpackage

FILE: rtl/core/pse_ctrl.sv
// controller state machine of the prime sieve engine
// depends on pse_pkg and prime_sieve_engine_core_defines.svh
`include "prime_sieve_engine_core_defines.svh"

module pse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               opcode,
	input  pse_pkg::pse_stat_t stat,
	output pse_pkg::pse_cmd_t  cmd,
	output logic               busy
);

	pse_pkg::pse_state_t state_q;
	pse_pkg::pse_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			pse_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (opcode == pse_pkg::OP_BUILD) begin
						cmd.build_load = 1'b1;
						state_d        = pse_pkg::ST_INIT;
					end else begin
						cmd.qry_load = 1'b1;
					end
				end
			end
			pse_pkg::ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (stat.init_last) begin
					state_d = pse_pkg::ST_FREAD;
				end
			end
			pse_pkg::ST_FREAD: begin
				cmd.rd_factor = 1'b1;
				if (stat.sq_over) begin
					state_d = pse_pkg::ST_DONE;
				end else begin
					state_d = pse_pkg::ST_FCHECK;
				end
			end
			pse_pkg::ST_FCHECK: begin
				if (stat.factor_prime) begin
					cmd.strike_load = 1'b1;
					state_d         = pse_pkg::ST_STRIKE;
				end else begin
					cmd.next_factor = 1'b1;
					state_d         = pse_pkg::ST_FREAD;
				end
			end
			pse_pkg::ST_STRIKE: begin
				cmd.strike_wr = 1'b1;
				if (stat.strike_last) begin
					cmd.next_factor = 1'b1;
					state_d         = pse_pkg::ST_FREAD;
				end
			end
			pse_pkg::ST_DONE: begin
				cmd.done = 1'b1;
				state_d  = pse_pkg::ST_IDLE;
			end
			default: begin
				state_d = pse_pkg::ST_IDLE;
			end
		endcase
	end

	`PSE_ASSERT_NEXT(a_build_enters_init, cmd.build_load, state_q == pse_pkg::ST_INIT,
		"build beat did not start the init sweep")
	`PSE_ASSERT_NOW(a_single_write, 1'b1, !(cmd.init_wr && cmd.strike_wr),
		"two table writes in one cycle")
	`PSE_ASSERT_NEXT(a_done_returns_idle, cmd.done, !busy,
		"engine still busy after build result")

endmodule

FILE: rtl/core/pse_datapath.sv
// datapath of the prime sieve engine: bit table, counters, limit and result regs
// depends on pse_pkg and prime_sieve_engine_core_defines.svh
`include "prime_sieve_engine_core_defines.svh"

module pse_datapath #(
	parameter int TABLE_DEPTH = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [pse_pkg::VAL_W-1:0] cfg_wr_data,
	input  logic [pse_pkg::VAL_W-1:0] query_value,
	input  pse_pkg::pse_cmd_t         cmd,
	output pse_pkg::pse_stat_t        stat,
	output logic                      done,
	output logic                      prime_flag,
	output logic [1:0]                status
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [pse_pkg::VAL_W-1:0] MAX_V =
		(TABLE_DEPTH - 1 > 65535) ? 16'hFFFF : 16'(TABLE_DEPTH - 1);

	logic                      prime_bits_q [TABLE_DEPTH];
	logic [pse_pkg::VAL_W-1:0] sieve_limit_q;
	logic [pse_pkg::VAL_W-1:0] lim_q;
	logic                      valid_q;
	logic [pse_pkg::CNT_W-1:0] m_q;
	logic [pse_pkg::FAC_W-1:0] f_q;
	logic [pse_pkg::CNT_W-1:0] sq_q;
	logic                      rd_bit_q;
	logic                      qry_s1;
	logic [1:0]                status_s1;
	logic [pse_pkg::VAL_W-1:0] lim_clamped;
	logic [pse_pkg::CNT_W-1:0] lim_ext;
	logic [pse_pkg::CNT_W-1:0] m_next_strike;
	logic [AW-1:0]             wr_addr;
	logic [AW-1:0]             rd_addr;
	logic                      wr_en;
	logic                      wr_bit;

	assign lim_clamped   = (sieve_limit_q > MAX_V) ? MAX_V : sieve_limit_q;
	assign lim_ext       = pse_pkg::CNT_W'(lim_q);
	assign m_next_strike = m_q + pse_pkg::CNT_W'(f_q);

	assign stat.init_last    = (m_q == lim_ext);
	assign stat.sq_over      = (sq_q > lim_ext);
	assign stat.factor_prime = rd_bit_q;
	assign stat.strike_last  = (m_next_strike > lim_ext);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sieve_limit_q <= pse_pkg::LIMIT_RESET;
			lim_q         <= '0;
			valid_q       <= 1'b0;
			qry_s1        <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sieve_limit_q <= cfg_wr_data;
			end
			if (cmd.build_load) begin
				lim_q <= lim_clamped;
			end
			if (cmd.done) begin
				valid_q <= 1'b1;
			end
			qry_s1 <= cmd.qry_load;
		end
	end

	// sweep and factor counters
	always_ff @(posedge clk) begin
		if (cmd.build_load) begin
			m_q  <= '0;
			f_q  <= pse_pkg::FAC_W'(2);
			sq_q <= pse_pkg::CNT_W'(4);
		end else begin
			if (cmd.init_wr) begin
				m_q <= m_q + pse_pkg::CNT_W'(1);
			end else if (cmd.strike_load) begin
				m_q <= sq_q;
			end else if (cmd.strike_wr) begin
				m_q <= m_next_strike;
			end
			if (cmd.next_factor) begin
				f_q  <= f_q + pse_pkg::FAC_W'(1);
				sq_q <= sq_q + pse_pkg::CNT_W'({f_q, 1'b1});
			end
		end
	end

	// query status
	always_ff @(posedge clk) begin
		if (!valid_q) begin
			status_s1 <= pse_pkg::STAT_NO_BUILD;
		end else if (query_value > lim_q) begin
			status_s1 <= pse_pkg::STAT_RANGE;
		end else begin
			status_s1 <= pse_pkg::STAT_OK;
		end
	end

	// bit table
	assign wr_en   = cmd.init_wr | cmd.strike_wr;
	assign wr_bit  = cmd.init_wr & (m_q >= pse_pkg::CNT_W'(2));
	assign wr_addr = AW'(m_q);
	assign rd_addr = cmd.rd_factor ? AW'(f_q) : AW'(query_value);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			prime_bits_q[wr_addr] <= wr_bit;
		end
	end

	always_ff @(posedge clk) begin
		rd_bit_q <= prime_bits_q[rd_addr];
	end

	assign done       = qry_s1 | cmd.done;
	assign prime_flag = qry_s1 & (status_s1 == pse_pkg::STAT_OK) & rd_bit_q;
	assign status     = qry_s1 ? status_s1 : pse_pkg::STAT_OK;

	`PSE_ASSERT_NOW(a_no_result_clash, qry_s1, !cmd.done,
		"query and build results in the same cycle")
	`PSE_ASSERT_NOW(a_strike_in_range, cmd.strike_wr, m_q <= lim_ext && m_q >= sq_q,
		"strike write outside the sieved range")
	`PSE_ASSERT_NOW(a_init_in_range, cmd.init_wr, m_q <= lim_ext,
		"init sweep ran past the limit")

endmodule

FILE: rtl/core/prime_sieve_engine_core.sv
// top level of the prime sieve engine: controller plus datapath
// depends on pse_pkg, pse_ctrl and pse_datapath
//
// channel   dir  handshake            payload
// command   in   start & !busy        opcode, query_value
// result    out  done (one cycle)     prime_flag, status
// config    in   cfg_wr_en            cfg_wr_data (sieve limit)
//
// query: one beat per idle cycle; result the cycle after acceptance (one table read)
// build: init sweep of entries 0..L, a table read per factor f with f*f <= L,
//   strike of f*f..L per prime f; L is the clamped limit; busy stays high throughout
// reset clears control state only; the bit table is written by the first build
// the receiver cannot stall; results are dropped if not taken
module prime_sieve_engine_core #(
	parameter int TABLE_DEPTH = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      opcode,
	input  logic [pse_pkg::VAL_W-1:0] query_value,
	input  logic                      cfg_wr_en,
	input  logic [pse_pkg::VAL_W-1:0] cfg_wr_data,
	output logic                      done,
	output logic                      prime_flag,
	output logic [1:0]                status
);

	pse_pkg::pse_cmd_t  cmd;
	pse_pkg::pse_stat_t stat;

	pse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	pse_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.query_value (query_value),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.prime_flag  (prime_flag),
		.status      (status)
	);

endmodule
